// ===== sv/rwev_pkg.sv =====
// Package for the rough-wall eddy viscosity pipeline: constants, stage map, stage record, helpers.
package rwev_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_CMU_FOURTH_ROOT = 2'd0;
    localparam logic [1:0] CFG_VON_KARMAN      = 2'd1;

    localparam logic [15:0] CMU_RESET   = 16'd35895;
    localparam logic [15:0] KAPPA_RESET = 16'd26870;

    // ln 2 in Q.26 and ln(1.0001) in Q.32
    localparam logic [25:0] LN2_Q26      = 26'd46516320;
    localparam logic [37:0] LN_FLOOR_Q32 = 38'd429475;
    localparam logic [47:0] OUT_MAX      = 48'h7FFF_FFFF_FFFF;

    // Stage map: sqrt and log paths run side by side, then the divider
    localparam int ST_MSB     = 1;
    localparam int ST_NORM    = 2;
    localparam int ST_SQ_FIRST = 3;
    localparam int ST_SQ_LAST  = 34;
    localparam int ST_LDIFF   = 35;
    localparam int ST_LNSCALE = 36;
    localparam int ST_RT_FIRST = 1;
    localparam int ST_RT_LAST  = 24;
    localparam int ST_USTAR   = 25;
    localparam int ST_KAPPA   = 26;
    localparam int ST_PLO     = 27;
    localparam int ST_NUM     = 28;
    localparam int ST_DIV0    = 37;
    localparam int ST_DV_FIRST = 38;
    localparam int ST_DV_LAST  = 85;
    localparam int ST_OUT     = 86;
    localparam int NUM_STAGES = 87;

    typedef struct packed {
        logic        bad;
        logic [31:0] nu;
        logic [31:0] y;
        logic [32:0] xa;
        logic [31:0] xb;
        logic [47:0] sq_v;
        logic [23:0] sq_r;
        logic [24:0] sq_rem;
        logic [39:0] pp;
        logic [51:0] plo;
        logic [87:0] num;
        logic [5:0]  ma;
        logic [5:0]  mb;
        logic [31:0] za;
        logic [31:0] zb;
        logic [31:0] fa;
        logic [31:0] fb;
        logic [37:0] ln;
        logic        over;
        logic [37:0] rem;
        logic [47:0] q;
        logic [47:0] res;
    } pipe_t;

    // Index of the top set bit, zero for inputs zero and one
    function automatic logic [5:0] msb33(input logic [32:0] x);
        logic [5:0] m;
        begin
            m = 6'd0;
            for (int b = 0; b < 33; b++) begin
                if (x[b]) m = 6'(b);
            end
            return m;
        end
    endfunction

    // Bring x to Q1.31 given its top bit index
    function automatic logic [31:0] norm33(input logic [32:0] x, input logic [5:0] m);
        logic [32:0] t;
        begin
            if (m >= 6'd31) t = x >> (m - 6'd31);
            else t = x << (6'd31 - m);
            return t[31:0];
        end
    endfunction

endpackage

// ===== sv/rough_wall_eddy_viscosity.sv =====
// Top level: rough-wall eddy viscosity, fully pipelined sqrt, log2 and divider datapath.
//
// Each face beat yields one result beat. A new face is taken every cycle while the output is not
// stalled. The pipeline has 87 register stages: the load stage, two log2 front-end stages, the
// 32-step log2 squaring chain, two log scaling stages, the divider setup stage and the 48-step
// restoring divider, one step per register stage, then the output stage. Each stage holds its
// beat until the next stage frees, so a stalled result lets upstream bubbles fill. Configuration
// registers are read live by the pipeline and may be written only while it is empty.
module rough_wall_eddy_viscosity import rwev_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [31:0]        s_turb_energy,
    input  logic [31:0]        s_wall_distance,
    input  logic [31:0]        s_wall_viscosity,
    input  logic [31:0]        s_roughness_length,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [47:0] m_eddy_viscosity,
    output logic               m_bad_roughness
);

    logic [15:0] cmu_reg;
    logic [15:0] kappa_reg;
    pipe_t       pipe_reg  [NUM_STAGES];
    pipe_t       pipe_next [NUM_STAGES];
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] adv;

    // One pipeline step; j selects which operations this stage performs
    function automatic pipe_t step(input int j, input pipe_t d,
                                   input logic [15:0] cmu, input logic [15:0] kap);
        pipe_t       o;
        logic [26:0] sr;
        logic [26:0] tr;
        logic [63:0] sa;
        logic [63:0] sb;
        logic [32:0] ta;
        logic [32:0] tb;
        logic [63:0] m1;
        logic [51:0] phi;
        logic [37:0] la;
        logic [37:0] lb;
        logic [38:0] r2;
        logic [48:0] d49;
        begin
            o = d;
            // square root, one result bit
            if (j >= ST_RT_FIRST && j <= ST_RT_LAST) begin
                sr = {d.sq_rem, d.sq_v[47:46]};
                tr = {1'b0, d.sq_r, 2'b01};
                o.sq_v = d.sq_v << 2;
                if (sr >= tr) begin
                    o.sq_rem = 25'(sr - tr);
                    o.sq_r   = {d.sq_r[22:0], 1'b1};
                end else begin
                    o.sq_rem = sr[24:0];
                    o.sq_r   = {d.sq_r[22:0], 1'b0};
                end
            end
            // uStar and the kappa product
            if (j == ST_USTAR) begin
                o.pp = {24'd0, cmu} * {16'd0, d.sq_r};
            end
            if (j == ST_KAPPA) begin
                m1   = {24'd0, d.pp} * {48'd0, kap};
                o.pp = m1[55:16];
            end
            // p times y, split into two 20-bit halves of p
            if (j == ST_PLO) begin
                o.plo = {32'd0, d.pp[19:0]} * {20'd0, d.y};
            end
            if (j == ST_NUM) begin
                phi   = {32'd0, d.pp[39:20]} * {20'd0, d.y};
                o.num = ({36'd0, phi} << 36) + ({36'd0, d.plo} << 16);
            end
            // log2 front end
            if (j == ST_MSB) begin
                o.ma = msb33(d.xa);
                o.mb = msb33({1'b0, d.xb});
            end
            if (j == ST_NORM) begin
                o.za = norm33(d.xa, d.ma);
                o.zb = norm33({1'b0, d.xb}, d.mb);
                o.fa = '0;
                o.fb = '0;
            end
            // one fraction bit by squaring
            if (j >= ST_SQ_FIRST && j <= ST_SQ_LAST) begin
                sa   = {32'd0, d.za} * {32'd0, d.za};
                sb   = {32'd0, d.zb} * {32'd0, d.zb};
                ta   = sa[63:31];
                tb   = sb[63:31];
                o.fa = {d.fa[30:0], ta[32]};
                o.fb = {d.fb[30:0], tb[32]};
                o.za = ta[32] ? ta[32:1] : ta[31:0];
                o.zb = tb[32] ? tb[32:1] : tb[31:0];
            end
            if (j == ST_LDIFF) begin
                la   = {d.ma, d.fa};
                lb   = {d.mb, d.fb};
                o.ln = (la > lb) ? (la - lb) : '0;
            end
            if (j == ST_LNSCALE) begin
                m1   = {26'd0, d.ln} * {38'd0, LN2_Q26};
                o.ln = (m1[63:26] < LN_FLOOR_Q32) ? LN_FLOOR_Q32 : m1[63:26];
            end
            // divider: high quotient part only flags overflow
            if (j == ST_DIV0) begin
                o.over = (d.num[87:48] >= {2'b00, d.ln});
                o.rem  = d.num[85:48];
                o.q    = '0;
            end
            if (j >= ST_DV_FIRST && j <= ST_DV_LAST) begin
                r2    = {d.rem, d.num[47]};
                o.num = d.num << 1;
                if (r2 >= {1'b0, d.ln}) begin
                    o.rem = 38'(r2 - {1'b0, d.ln});
                    o.q   = {d.q[46:0], 1'b1};
                end else begin
                    o.rem = r2[37:0];
                    o.q   = {d.q[46:0], 1'b0};
                end
            end
            // subtract nu and saturate
            if (j == ST_OUT) begin
                d49 = {1'b0, d.q} - {17'd0, d.nu};
                if (d.bad) o.res = '0;
                else if (d.over || (!d49[48] && d49[47])) o.res = OUT_MAX;
                else o.res = d49[47:0];
            end
            return o;
        end
    endfunction

    // Hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmu_reg   <= CMU_RESET;
            kappa_reg <= KAPPA_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_CMU_FOURTH_ROOT: cmu_reg   <= cfg_wdata;
                CFG_VON_KARMAN:      kappa_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Advance a stage when it is empty or its successor advances
    always_comb begin
        adv[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    // Load a face beat
    always_comb begin
        pipe_next[0]        = '0;
        pipe_next[0].bad    = (s_roughness_length == 32'd0);
        pipe_next[0].nu     = s_wall_viscosity;
        pipe_next[0].y      = s_wall_distance;
        pipe_next[0].xa     = {1'b0, s_wall_distance} + {1'b0, s_roughness_length};
        pipe_next[0].xb     = s_roughness_length;
        pipe_next[0].sq_v   = {s_turb_energy, 16'd0};
    end

    generate
        for (genvar g = 1; g < NUM_STAGES; g++) begin : g_step
            always_comb pipe_next[g] = step(g, pipe_reg[g-1], cmu_reg, kappa_reg);
        end
    endgenerate

    // Stage registers: valid bits under reset, payload without reset and loaded only with a valid beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[0]) vld_reg[0] <= s_valid;
            for (int i = 1; i < NUM_STAGES; i++) begin
                if (adv[i]) vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0] && s_valid) pipe_reg[0] <= pipe_next[0];
        for (int i = 1; i < NUM_STAGES; i++) begin
            if (adv[i] && vld_reg[i-1]) pipe_reg[i] <= pipe_next[i];
        end
    end

    assign s_ready          = adv[0];
    assign m_valid          = vld_reg[NUM_STAGES-1];
    assign m_eddy_viscosity = pipe_reg[NUM_STAGES-1].res;
    assign m_bad_roughness  = pipe_reg[NUM_STAGES-1].bad;

endmodule

// ===== dv/rough_wall_eddy_viscosity_test.sv =====
// Testbench for the rough-wall eddy viscosity pipeline: directed table, random faces, scoreboard.
`timescale 1ns / 100ps

module rough_wall_eddy_viscosity_test;
    import rwev_pkg::*;

    typedef struct {
        logic [31:0] k;
        logic [31:0] y;
        logic [31:0] nu;
        logic [31:0] z0;
    } face_t;

    typedef struct {
        logic signed [47:0] nut;
        logic               bad;
    } nut_t;

    typedef struct {
        face_t f;
        logic  known;
        nut_t  r;
    } face_row_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    logic [31:0]        s_turb_energy;
    logic [31:0]        s_wall_distance;
    logic [31:0]        s_wall_viscosity;
    logic [31:0]        s_roughness_length;
    logic               m_valid;
    logic               m_ready;
    logic signed [47:0] m_eddy_viscosity;
    logic               m_bad_roughness;

    rough_wall_eddy_viscosity i_dut (.*);

    // Predictor copies of the two registers
    logic [15:0] cmu_q16;
    logic [15:0] kappa_q16;

    nut_t        nut_pending[$];
    int          errors;
    int          mismatches;
    int          faces_sent;
    int          results_seen;
    int          bad_seen;
    int          sat_seen;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_off;
    longint      cycles;
    logic        finished;

    localparam longint CYCLE_LIMIT = 400000;

    // Clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // log2 in Q.32 by repeated squaring of the Q1.31 mantissa
    function automatic logic [63:0] log2_fix(input logic [63:0] x);
        int          top;
        logic [63:0] z;
        logic [31:0] frac;
        top = 0;
        while (top < 63 && (x >> (top + 1)) != 0) top++;
        if (top >= 31) z = x >> (top - 31);
        else z = x << (31 - top);
        frac = 0;
        for (int i = 0; i < 32; i++) begin
            z    = (z * z) >> 31;
            frac = frac << 1;
            if (z >= 64'h1_0000_0000) begin
                z       = z >> 1;
                frac[0] = 1'b1;
            end
        end
        return {top[31:0], frac};
    endfunction

    function automatic nut_t predict_nut(input face_t f);
        nut_t          r;
        logic [63:0]   s, u, p, la, lb, l2, ln;
        logic [127:0]  num;
        logic [127:0]  quo;
        logic [63:0]   q;
        logic signed [64:0] d;
        if (f.z0 == 0) begin
            r.nut = 0;
            r.bad = 1'b1;
            return r;
        end
        s   = isqrt({32'd0, f.k} << 16);
        u   = cmu_q16 * s;
        p   = (u * kappa_q16) >> 16;
        num = (128'(p) * 128'(f.y)) << 16;
        la  = log2_fix(64'(f.y) + 64'(f.z0));
        lb  = log2_fix(64'(f.z0));
        l2  = (la > lb) ? la - lb : 64'd0;
        ln  = (l2 * 64'(LN2_Q26)) >> 26;
        if (ln < 64'(LN_FLOOR_Q32)) ln = 64'(LN_FLOOR_Q32);
        quo = num / 128'(ln);
        q   = (quo > (128'd1 << 62)) ? (64'd1 << 62) : quo[63:0];
        d   = $signed({1'b0, q}) - $signed({33'd0, f.nu});
        if (d > $signed(65'(OUT_MAX))) d = 65'(OUT_MAX);
        r.nut = d[47:0];
        r.bad = 1'b0;
        return r;
    endfunction

    function automatic face_t rand_face();
        face_t f;
        f.k  = $urandom;
        f.y  = $urandom;
        f.nu = $urandom;
        f.z0 = $urandom;
        // Bias toward physical sizes so the log and quotient span many ranges
        case ($urandom_range(0, 5))
            0: f.k = $urandom_range(0, 32'h0004_0000);
            1: begin
                f.y  = $urandom_range(1, 32'h0002_0000);
                f.z0 = $urandom_range(1, 32'h0000_1000);
            end
            2: f.z0 = $urandom_range(0, 3);
            3: begin
                f.z0 = $urandom_range(32'h1000_0000, 32'hFFFF_FFFF);
                f.y  = $urandom_range(0, 32'h100);
            end
            default: ;
        endcase
        return f;
    endfunction

    task automatic send_face(input face_t f);
        nut_pending.push_back(predict_nut(f));
        s_valid            <= 1'b1;
        s_turb_energy      <= f.k;
        s_wall_distance    <= f.y;
        s_wall_viscosity   <= f.nu;
        s_roughness_length <= f.z0;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        faces_sent++;
        @(negedge aclk);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
    endtask

    // Idle the channel and wait for the pipe to drain before a register write
    task automatic drain_pipe();
        s_valid <= 1'b0;
        while (nut_pending.size() != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_CMU_FOURTH_ROOT) cmu_q16 = val;
        else if (idx == CFG_VON_KARMAN) kappa_q16 = val;
    endtask

    // Result checker
    always @(posedge aclk) begin
        nut_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (m_bad_roughness) bad_seen++;
            if (m_eddy_viscosity == $signed(OUT_MAX)) sat_seen++;
            if (nut_pending.size() == 0) begin
                errors++;
                if (mismatches++ < 10) $display("unexpected result beat %0d", m_eddy_viscosity);
            end else begin
                want = nut_pending.pop_front();
                if (want.nut !== m_eddy_viscosity || want.bad !== m_bad_roughness) begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("mismatch: expected nut %0d bad %0b, got nut %0d bad %0b",
                                 want.nut, want.bad, m_eddy_viscosity, m_bad_roughness);
                end
            end
        end
    end

    // Receiver stalls, with a long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off > 0) begin
                m_ready <= 1'b0;
                hold_off--;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT && !finished) begin
                $display("timeout after %0d cycles", cycles);
                $display("rough_wall_eddy_viscosity_test NOT OK");
                $finish;
            end
        end
    end

    face_row_t rows[$];
    face_t     f;
    nut_t      chk_r;
    logic [15:0] cmu_set[4]   = '{16'd0, 16'hFFFF, 16'd35895, 16'd1};
    logic [15:0] kappa_set[4] = '{16'hFFFF, 16'd0, 16'd26870, 16'hFFFF};

    initial begin
        finished           = 1'b0;
        errors             = 0;
        mismatches         = 0;
        faces_sent         = 0;
        results_seen       = 0;
        bad_seen           = 0;
        sat_seen           = 0;
        hold_off           = 0;
        send_idle_pct      = 0;
        recv_idle_pct      = 0;
        aresetn            = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_index          = CFG_CMU_FOURTH_ROOT;
        cfg_wdata          = 16'd0;
        s_valid            = 1'b0;
        s_turb_energy      = 0;
        s_wall_distance    = 0;
        s_wall_viscosity   = 0;
        s_roughness_length = 0;
        cmu_q16            = CMU_RESET;
        kappa_q16          = KAPPA_RESET;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;

        // Directed table: zero roughness, zero k/y/nu, ratio floor, saturation, extremes
        rows = '{
            '{'{32'd0, 32'd0, 32'd0, 32'd0}, 1'b1, '{48'sd0, 1'b1}},
            '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0}, 1'b1, '{48'sd0, 1'b1}},
            '{'{32'd0, 32'h0001_0000, 32'd12345, 32'h0000_1000}, 1'b1, '{-48'sd12345, 1'b0}},
            '{'{32'h0001_0000, 32'd0, 32'hFFFF_FFFF, 32'h0000_0100}, 1'b1,
              '{-48'sd4294967295, 1'b0}},
            '{'{32'h0001_0000, 32'd0, 32'd0, 32'd1}, 1'b1, '{48'sd0, 1'b0}},
            '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd1}, 1'b1, '{$signed(OUT_MAX), 1'b0}},
            '{'{32'hFFFF_FFFF, 32'd1, 32'd0, 32'hFFFF_FFFF}, 1'b0, '{48'sd0, 1'b0}},
            '{'{32'h0001_0000, 32'h0001_0000, 32'd0, 32'h0000_1000}, 1'b0, '{48'sd0, 1'b0}},
            '{'{32'h0000_8000, 32'h000A_0000, 32'd1000, 32'h0000_0CCD}, 1'b0, '{48'sd0, 1'b0}},
            '{'{32'd1, 32'd1, 32'd1, 32'd1}, 1'b0, '{48'sd0, 1'b0}},
            '{'{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555}, 1'b0,
              '{48'sd0, 1'b0}},
            '{'{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA}, 1'b0,
              '{48'sd0, 1'b0}},
            '{'{32'h8000_0000, 32'h0000_0001, 32'h8000_0000, 32'h8000_0000}, 1'b0,
              '{48'sd0, 1'b0}},
            '{'{32'h0064_0000, 32'h03E8_0000, 32'd0, 32'h0000_0001}, 1'b0, '{48'sd0, 1'b0}}
        };
        // Send rows back to back; each send returns at a falling edge ready for the next
        foreach (rows[i]) begin
            if (rows[i].known) begin
                chk_r = predict_nut(rows[i].f);
                if (chk_r.nut !== rows[i].r.nut || chk_r.bad !== rows[i].r.bad) begin
                    errors++;
                    $display("predictor disagrees with table row %0d", i);
                end
            end
            send_face(rows[i].f);
        end
        drain_pipe();

        // Random phases over register settings and idle patterns
        for (int ph = 0; ph < 6; ph++) begin
            if (ph < 4) begin
                write_reg(CFG_CMU_FOURTH_ROOT, cmu_set[ph]);
                write_reg(CFG_VON_KARMAN, kappa_set[ph]);
            end else begin
                write_reg(CFG_CMU_FOURTH_ROOT, 16'($urandom));
                write_reg(CFG_VON_KARMAN, 16'($urandom));
            end
            for (int n = 0; n < 140; n++) begin
                if (n < 47) begin
                    send_idle_pct = 33; recv_idle_pct = 70;
                end else if (n < 94) begin
                    send_idle_pct = 70; recv_idle_pct = 33;
                end else begin
                    send_idle_pct = 0; recv_idle_pct = 0;
                end
                // Long receiver hold-off so the pipe fills and back-pressures
                if (n == 100 && ph == 1) hold_off = 300;
                f = rand_face();
                send_face(f);
            end
            // Sender pauses until all results are back
            drain_pipe();
        end

        while (nut_pending.size() != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
        finished = 1'b1;
        $display("faces sent %0d, results checked %0d, zero-roughness %0d, saturated %0d",
                 faces_sent, results_seen, bad_seen, sat_seen);
        $display("covered reset, extreme and random register settings under varied stalls");
        if (errors == 0) begin
            $display("rough_wall_eddy_viscosity_test OK");
        end else begin
            $display("rough_wall_eddy_viscosity_test NOT OK");
        end
        $finish;
    end

endmodule
